### rtl/core/kbq_pkg.sv
// Package for the knob and button qualifier: register indexes, reset values,
// field positions in the request and response words.
// No dependencies.
package kbq_pkg;

   // Number of knob lanes carried on the ports; NUM_KNOBS may use fewer.
   localparam int KNOB_MAX      = 4;
   localparam int NUM_KNOBS_DEF = 4;

   localparam int SAMPLE_W = 10;
   localparam int VALUE_W  = 8;
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 16;

   // Request word layout.
   localparam int REQ_NOW_LSB    = 0;
   localparam int REQ_BUTTON_BIT = REQ_NOW_LSB + TIME_W;
   localparam int REQ_SAMPLE_LSB = REQ_BUTTON_BIT + 1;
   localparam int REQ_REARM_LSB  = REQ_SAMPLE_LSB + KNOB_MAX * SAMPLE_W;
   localparam int REQ_BITS       = REQ_REARM_LSB + KNOB_MAX;
   localparam int REQ_W          = ((REQ_BITS + 7) / 8) * 8;

   // Response word layout.
   localparam int RSP_BITS = 3 + 2 * KNOB_MAX + KNOB_MAX * VALUE_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INVERT_KNOBS  = 2'd0,
      CSR_DEAD_BAND     = 2'd1,
      CSR_CLICK_MAX_MS  = 2'd2,
      CSR_LONG_PRESS_MS = 2'd3
   } csr_index_type;

   localparam logic [VALUE_W-1:0] DEAD_BAND_RST     = 8'd16;
   localparam logic [LIMIT_W-1:0] CLICK_MAX_MS_RST  = 16'd1000;
   localparam logic [LIMIT_W-1:0] LONG_PRESS_MS_RST = 16'd2000;

endpackage

### rtl/core/knob_and_button_qualifier.sv
// Knob and button qualifier: one scan in, one qualified result out.
// Depends on kbq_pkg for field layout, register indexes and reset values.
//
// A result is registered after its scan is accepted. Throughput: one scan
// per cycle while the skid register is empty, limited only by the single
// pass of per-knob compare logic and the 32-bit elapsed-time subtract.
// A two-entry output buffer (result register plus skid register) keeps the
// request side open while one finished word waits to be taken.
// Reset is synchronous and active high; it restores the register defaults
// and returns the block to the unprimed state, so the next scan re-anchors.
module knob_and_button_qualifier
   import kbq_pkg::*;
#(
   parameter int NUM_KNOBS = NUM_KNOBS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Scan input. tdata, lowest bit up: now_ms[31:0], button_level[32],
   // knob_sample_0[42:33], knob_sample_1[52:43], knob_sample_2[62:53],
   // knob_sample_3[72:63], rearm_mask[76:73], zero padding[79:77].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,
   // Result output. tdata, lowest bit up: click[0], long_press[1],
   // button_down[2], new_value_mask[6:3], new_value_pressed_mask[10:7],
   // knob_value_0[18:11], knob_value_1[26:19], knob_value_2[34:27],
   // knob_value_3[42:35], zero padding[47:43].
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic               invert_ff;
   logic [VALUE_W-1:0] dead_band_ff;
   logic [LIMIT_W-1:0] click_max_ff;
   logic [LIMIT_W-1:0] long_press_ff;

   // Button state.
   logic              primed_ff, primed_in;
   logic              pressed_ff;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              moved_ff, moved_in;
   logic              long_done_ff, long_done_in;

   // Output buffer.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RSP_W-1:0] skid_data_ff, skid_data_in;

   logic              accept;
   logic [TIME_W-1:0] now_ms;
   logic              pressed_scan;
   logic              press_rise;
   logic              btn_change;
   logic [KNOB_MAX-1:0] rearm_mask;
   logic [KNOB_MAX-1:0] mark_next;
   logic [VALUE_W-1:0]  held_next [KNOB_MAX];
   logic [KNOB_MAX-1:0] released_mask;
   logic [KNOB_MAX-1:0] pressed_mask;
   logic [TIME_W-1:0]   elapsed;
   logic                click;
   logic                long_press;
   logic [RSP_W-1:0]    result_word;

   assign accept       = req_tvalid & req_tready;
   assign req_tready   = ~skid_valid_ff;
   assign csr_ready    = 1'b1;

   assign now_ms       = req_tdata[REQ_NOW_LSB +: TIME_W];
   assign pressed_scan = ~req_tdata[REQ_BUTTON_BIT];
   assign rearm_mask   = req_tdata[REQ_REARM_LSB +: KNOB_MAX];

   // The very first scan sees the button as previously released, so a button
   // already held at start-up opens a press.
   assign press_rise = ~pressed_ff & pressed_scan;
   assign btn_change = pressed_ff ^ pressed_scan;

   // Per-knob lanes. Each lane applies re-arm, priming, the dead-band test
   // and the clearing on a button change, in that order, within one pass.
   for (genvar g = 0; g < KNOB_MAX; g++) begin : g_lane
      if (g < NUM_KNOBS) begin : g_used
         logic               mark_ff, mark_in;
         logic [VALUE_W-1:0] anchor_ff, anchor_in;
         logic [VALUE_W-1:0] latest_ff;
         logic [VALUE_W-1:0] held_ff;
         logic [VALUE_W-1:0] cur;
         logic [VALUE_W-1:0] anchor_rearm;
         logic [VALUE_W-1:0] anchor_base;
         logic [VALUE_W-1:0] held_base;
         logic [VALUE_W-1:0] diff;
         logic               mark_base;
         logic               mark_moved;

         always_comb begin
            cur = req_tdata[REQ_SAMPLE_LSB + g * SAMPLE_W + (SAMPLE_W - VALUE_W) +: VALUE_W];
            if (invert_ff) begin
               cur = ~cur;
            end
            anchor_rearm = rearm_mask[g] ? latest_ff : anchor_ff;
            anchor_base  = primed_ff ? anchor_rearm : cur;
            mark_base    = primed_ff & mark_ff & ~rearm_mask[g];
            held_base    = primed_ff ? held_ff : cur;
            diff         = (cur > anchor_base) ? (cur - anchor_base) : (anchor_base - cur);
            mark_moved   = mark_base | (diff > dead_band_ff);
            held_next[g] = mark_moved ? cur : held_base;
            mark_in      = mark_moved & ~btn_change;
            anchor_in    = btn_change ? cur : anchor_base;
            mark_next[g] = mark_in;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mark_ff <= 1'b0;
            end else if (accept) begin
               mark_ff <= mark_in;
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               anchor_ff <= anchor_in;
               latest_ff <= cur;
               held_ff   <= held_next[g];
            end
         end
      end else begin : g_unused
         assign mark_next[g] = 1'b0;
         assign held_next[g] = '0;
      end
   end

   // Button bookkeeping. A press edge restarts the timer and both flags;
   // any movement seen while pressed rules out click and long press.
   always_comb begin
      primed_in      = 1'b1;
      press_start_in = press_rise ? now_ms : press_start_ff;
      released_mask  = mark_next & {KNOB_MAX{~pressed_scan}};
      pressed_mask   = mark_next & {KNOB_MAX{pressed_scan}};
      moved_in       = (moved_ff & ~press_rise) | (|pressed_mask);
      elapsed        = now_ms - press_start_in;
      click          = pressed_ff & ~pressed_scan & ~moved_in
                       & (elapsed < {{(TIME_W-LIMIT_W){1'b0}}, click_max_ff});
      long_press     = ~(long_done_ff & ~press_rise) & pressed_scan & ~moved_in
                       & (elapsed > {{(TIME_W-LIMIT_W){1'b0}}, long_press_ff});
      long_done_in   = (long_done_ff & ~press_rise) | long_press;
   end

   assign result_word = {{(RSP_W-RSP_BITS){1'b0}},
                         held_next[3], held_next[2], held_next[1], held_next[0],
                         pressed_mask, released_mask,
                         pressed_scan, long_press, click};

   // Output buffer: a word goes straight to the result register when it is
   // free or being emptied, otherwise into the skid register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         primed_ff     <= 1'b0;
         pressed_ff    <= 1'b0;
         moved_ff      <= 1'b0;
         long_done_ff  <= 1'b0;
         invert_ff     <= 1'b0;
         dead_band_ff  <= DEAD_BAND_RST;
         click_max_ff  <= CLICK_MAX_MS_RST;
         long_press_ff <= LONG_PRESS_MS_RST;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            primed_ff    <= primed_in;
            pressed_ff   <= pressed_scan;
            moved_ff     <= moved_in;
            long_done_ff <= long_done_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_INVERT_KNOBS:  invert_ff     <= csr_data[0];
               CSR_DEAD_BAND:     dead_band_ff  <= csr_data[VALUE_W-1:0];
               CSR_CLICK_MAX_MS:  click_max_ff  <= csr_data;
               CSR_LONG_PRESS_MS: long_press_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff    <= rsp_data_in;
      skid_data_ff   <= skid_data_in;
      if (accept) begin
         press_start_ff <= press_start_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The skid register only fills behind an occupied result register.
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a word while the result register is empty");

   // A click and a long press cannot come from the same scan.
   a_click_long_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[1]))
      else $error("click and long press reported together");

   // The two movement masks split by button level and never overlap.
   a_masks_split : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[6:3] & rsp_data_ff[10:7]) == '0)
                       && (rsp_data_ff[2] || rsp_data_ff[10:7] == '0)
                       && (!rsp_data_ff[2] || rsp_data_ff[6:3] == '0))
      else $error("movement masks disagree with the button level");

   // After a long press has been reported it stays done until the next press.
   a_long_once : assert property (@(posedge clock) disable iff (reset)
      accept && long_done_ff && !press_rise |=> long_done_ff)
      else $error("long press re-armed without a new press");

   // A scan accepted while the response side is stalled must not be lost.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      accept && rsp_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("accepted word was not captured by the skid register");

endmodule

### tb/sv/kbq_checker.sv
// Checker for the knob and button qualifier: watches the scan, result and register
// channels, predicts each result word and compares it field by field.
// Depends on kbq_pkg for field layout and register indexes.
module kbq_checker
   import kbq_pkg::*;
#(
   parameter int NUM_KNOBS = NUM_KNOBS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_W-1:0]       rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     error_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Result word positions, lowest bit up.
   localparam int RSP_CLICK_BIT = 0;
   localparam int RSP_LONG_BIT  = 1;
   localparam int RSP_DOWN_BIT  = 2;
   localparam int RSP_IDLE_LSB  = 3;
   localparam int RSP_HELD_LSB  = RSP_IDLE_LSB + KNOB_MAX;
   localparam int RSP_VALUE_LSB = RSP_HELD_LSB + KNOB_MAX;

   typedef struct packed {
      logic                             click;
      logic                             long_press;
      logic                             button_down;
      logic [KNOB_MAX-1:0]              idle_moves;
      logic [KNOB_MAX-1:0]              held_moves;
      logic [KNOB_MAX-1:0][VALUE_W-1:0] values;
   } scan_outcome_type;

   // Register copies.
   logic               invert;
   logic [VALUE_W-1:0] band;
   logic [LIMIT_W-1:0] click_lim;
   logic [LIMIT_W-1:0] long_lim;

   // Qualifier state.
   logic                             seen_first;
   logic                             btn_down;
   logic                             btn_was_down;
   logic [TIME_W-1:0]                press_t0;
   logic                             nudged_in_press;
   logic                             long_sent;
   logic [KNOB_MAX-1:0]              moving;
   logic [KNOB_MAX-1:0][VALUE_W-1:0] anchor;
   logic [KNOB_MAX-1:0][VALUE_W-1:0] last_val;
   logic [KNOB_MAX-1:0][VALUE_W-1:0] held;

   scan_outcome_type pending_results[$];
   int               mismatch_total = 0;

   function automatic scan_outcome_type qualify_scan(input logic [REQ_W-1:0] word);
      scan_outcome_type                 r;
      logic [TIME_W-1:0]                now;
      logic [TIME_W-1:0]                elapsed;
      logic [KNOB_MAX-1:0]              rearm;
      logic [KNOB_MAX-1:0][VALUE_W-1:0] cur;
      logic [SAMPLE_W-1:0]              raw;
      logic [VALUE_W-1:0]               gap;
      r     = '0;
      cur   = '0;
      now   = word[REQ_NOW_LSB +: TIME_W];
      rearm = word[REQ_REARM_LSB +: KNOB_MAX];

      // The top eight bits of each sample are kept; a re-arm drops the mark and
      // takes the sample of the previous scan as the new anchor.
      for (int k = 0; k < NUM_KNOBS; k++) begin
         raw    = word[REQ_SAMPLE_LSB + k * SAMPLE_W +: SAMPLE_W];
         cur[k] = raw[SAMPLE_W-1 -: VALUE_W];
         if (invert) begin
            cur[k] = 8'd255 - cur[k];
         end
         if (rearm[k]) begin
            moving[k] = 1'b0;
            anchor[k] = last_val[k];
         end
      end

      if (!seen_first) begin
         for (int k = 0; k < NUM_KNOBS; k++) begin
            anchor[k]   = cur[k];
            last_val[k] = cur[k];
            held[k]     = cur[k];
            moving[k]   = 1'b0;
         end
         seen_first = 1'b1;
      end

      btn_was_down = btn_down;
      btn_down     = !word[REQ_BUTTON_BIT];

      for (int k = 0; k < NUM_KNOBS; k++) begin
         gap         = (cur[k] > anchor[k]) ? cur[k] - anchor[k] : anchor[k] - cur[k];
         last_val[k] = cur[k];
         if (!moving[k] && gap > band) begin
            moving[k] = 1'b1;
         end
         if (moving[k]) begin
            held[k] = cur[k];
         end
      end

      if (!btn_was_down && btn_down) begin
         press_t0        = now;
         nudged_in_press = 1'b0;
         long_sent       = 1'b0;
      end

      // Either button edge starts the knobs afresh from where they stand.
      if (btn_was_down != btn_down) begin
         for (int k = 0; k < NUM_KNOBS; k++) begin
            moving[k] = 1'b0;
            anchor[k] = last_val[k];
         end
      end

      for (int k = 0; k < NUM_KNOBS; k++) begin
         if (moving[k]) begin
            if (btn_down) begin
               r.held_moves[k] = 1'b1;
            end else begin
               r.idle_moves[k] = 1'b1;
            end
         end
         r.values[k] = held[k];
      end
      if (r.held_moves != '0) begin
         nudged_in_press = 1'b1;
      end

      elapsed = now - press_t0;
      r.click = btn_was_down && !btn_down && !nudged_in_press && elapsed < click_lim;
      if (!long_sent && btn_down && !nudged_in_press && elapsed > long_lim) begin
         long_sent    = 1'b1;
         r.long_press = 1'b1;
      end
      r.button_down = btn_down;
      return r;
   endfunction

   function automatic void compare_field(input string what, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         mismatch_total++;
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      scan_outcome_type want;
      if (reset) begin
         invert          = 1'b0;
         band            = DEAD_BAND_RST;
         click_lim       = CLICK_MAX_MS_RST;
         long_lim        = LONG_PRESS_MS_RST;
         seen_first      = 1'b0;
         btn_down        = 1'b0;
         btn_was_down    = 1'b0;
         press_t0        = '0;
         nudged_in_press = 1'b0;
         long_sent       = 1'b0;
         moving          = '0;
         anchor          = '0;
         last_val        = '0;
         held            = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_INVERT_KNOBS:  invert    = csr_data[0];
               CSR_DEAD_BAND:     band      = csr_data[VALUE_W-1:0];
               CSR_CLICK_MAX_MS:  click_lim = csr_data[LIMIT_W-1:0];
               CSR_LONG_PRESS_MS: long_lim  = csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         // A result is registered behind its scan, so the word taken at this edge
         // is compared before this edge's scan is predicted.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatch_total++;
               $display("%0t: result word with nothing expected, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               compare_field("click", want.click, rsp_tdata[RSP_CLICK_BIT]);
               compare_field("long_press", want.long_press, rsp_tdata[RSP_LONG_BIT]);
               compare_field("button_down", want.button_down, rsp_tdata[RSP_DOWN_BIT]);
               compare_field("new_value_mask", want.idle_moves,
                             rsp_tdata[RSP_IDLE_LSB +: KNOB_MAX]);
               compare_field("new_value_pressed_mask", want.held_moves,
                             rsp_tdata[RSP_HELD_LSB +: KNOB_MAX]);
               for (int k = 0; k < KNOB_MAX; k++) begin
                  compare_field($sformatf("knob_value_%0d", k), want.values[k],
                                rsp_tdata[RSP_VALUE_LSB + k * VALUE_W +: VALUE_W]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(qualify_scan(req_tdata));
         end
      end
      outstanding <= pending_results.size();
      error_count <= mismatch_total;
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the knob and button qualifier: clock, reset, scan stimulus,
// register writes, receiver stalls and the verdict.
// Depends on kbq_pkg, knob_and_button_qualifier and kbq_checker.
module tb;
   import kbq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The button pin is pulled up, so a low level means the button is held.
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   // Cycles without any word moving on any channel before the run is abandoned.
   localparam int QUIET_LIMIT = 1000;
   // Length of the deliberate receiver hold-off, long enough to fill the block.
   localparam int HOLD_CYCLES = 64;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 180;

   typedef logic [KNOB_MAX-1:0][SAMPLE_W-1:0] sample_lanes_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatches;
   int outstanding;

   // Idling controls. The sender's share is read only by the stimulus process;
   // the receiver's share and the hold-off request are handed over by NBA.
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_serial  = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   // Scan generator state: time, button level and where each knob rests.
   logic [TIME_W-1:0] sim_now;
   logic              sim_level;
   int                knob_base[KNOB_MAX];
   int                band_now;
   int                click_now;
   int                long_now;

   knob_and_button_qualifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   kbq_checker qualifier_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (mismatches),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // Receiver. A hold-off request from the stimulus starts a stretch of
   // HOLD_CYCLES with ready low, counted here; otherwise ready is drawn at
   // random against the stall share of the current phase.
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Watchdog: any word moving on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic sample_lanes_type lanes(input int raw);
      sample_lanes_type s;
      for (int k = 0; k < KNOB_MAX; k++) begin
         s[k] = SAMPLE_W'(raw);
      end
      return s;
   endfunction

   // Offers one scan word, after a random number of idle cycles when the phase
   // asks for them, and returns at the edge where the block takes it. The valid
   // is only lowered when an idle cycle follows, so it is never lowered and
   // raised at the same edge.
   task automatic offer_scan(input logic [TIME_W-1:0] now, input logic level,
                             input sample_lanes_type smp, input logic [KNOB_MAX-1:0] rearm);
      logic [REQ_W-1:0] word;
      word = '0;
      word[REQ_NOW_LSB +: TIME_W]                  = now;
      word[REQ_BUTTON_BIT]                         = level;
      word[REQ_SAMPLE_LSB +: KNOB_MAX * SAMPLE_W]  = smp;
      word[REQ_REARM_LSB +: KNOB_MAX]              = rearm;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted result has been taken.
   // Each scan gives exactly one result, so nothing is left in flight after that.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Brings the block to rest and loads a new register setting.
   task automatic retune(input int inv, input int band, input int click_ms, input int long_ms);
      wait_drained();
      write_reg(CSR_INVERT_KNOBS, CSR_DATA_W'(inv));
      write_reg(CSR_DEAD_BAND, CSR_DATA_W'(band));
      write_reg(CSR_CLICK_MAX_MS, CSR_DATA_W'(click_ms));
      write_reg(CSR_LONG_PRESS_MS, CSR_DATA_W'(long_ms));
      band_now  = band;
      click_now = click_ms;
      long_now  = long_ms;
   endtask

   // Random scans. Most are well-formed: time moves on in steps scaled to the
   // press limits, the button is held for a few scans at a time, and the knobs
   // jitter around a resting point close to the dead band with an occasional
   // real turn. A few scans are pure noise in every field.
   task automatic run_scans(input int count);
      sample_lanes_type    smp;
      logic [KNOB_MAX-1:0] rearm;
      int                  span;
      int                  jit;
      int                  pick;
      int                  v;
      span = ((click_now > long_now) ? click_now : long_now) / 4 + 8;
      jit  = (band_now * 4 + 4 > 512) ? 512 : band_now * 4 + 4;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            sim_now   = $urandom;
            sim_level = 1'($urandom);
            for (int k = 0; k < KNOB_MAX; k++) begin
               smp[k] = SAMPLE_W'($urandom_range(0, 1023));
            end
            rearm = KNOB_MAX'($urandom);
         end else begin
            if (pick < 9) begin
               sim_now += $urandom_range(0, 4 * span);
            end else begin
               sim_now += $urandom_range(1, span);
            end
            if ($urandom_range(99) < 10) begin
               sim_level = ~sim_level;
            end
            for (int k = 0; k < KNOB_MAX; k++) begin
               if ($urandom_range(99) < 4) begin
                  knob_base[k] = $urandom_range(0, 1023);
               end
               v = knob_base[k] + int'($urandom_range(0, jit)) - jit / 2;
               if (v < 0) begin
                  v = 0;
               end else if (v > 1023) begin
                  v = 1023;
               end
               smp[k] = SAMPLE_W'(v);
            end
            rearm = ($urandom_range(99) < 12) ? KNOB_MAX'($urandom) : '0;
         end
         offer_scan(sim_now, sim_level, smp, rearm);
      end
   endtask

   initial begin
      sample_lanes_type mix;
      mix = {10'h2AA, 10'h155, 10'h3FF, 10'h000};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed scans with the reset register values: dead band 16, click
      // under 1000 ms, long press over 2000 ms, no inversion.
      // The first scan primes the anchors with the button already held and
      // every re-arm bit set, which also counts as a press edge.
      offer_scan(32'd0, LEVEL_PRESSED, lanes(0), 4'hF);
      // Short release: a click.
      offer_scan(32'd500, LEVEL_RELEASED, lanes(0), '0);
      // Full-scale turn on every knob with the button up.
      offer_scan(32'd600, LEVEL_RELEASED, lanes(1023), '0);
      // Re-arm all knobs and then some while the samples differ per knob.
      offer_scan(32'd700, LEVEL_RELEASED, mix, 4'hF);
      offer_scan(32'd800, LEVEL_RELEASED, mix, 4'h5);
      // A press just before the timestamp wraps; the hold is measured across
      // the wrap and gives exactly one long-press pulse.
      offer_scan(32'hFFFF_FC00, LEVEL_PRESSED, mix, '0);
      offer_scan(32'h0000_02FF, LEVEL_PRESSED, mix, '0);
      offer_scan(32'h0000_0400, LEVEL_PRESSED, mix, '0);
      offer_scan(32'h0000_0500, LEVEL_PRESSED, mix, '0);
      offer_scan(32'h0000_0600, LEVEL_RELEASED, mix, '0);
      // A knob turned during a short press suppresses the click.
      offer_scan(32'h0001_0000, LEVEL_PRESSED, mix, '0);
      offer_scan(32'h0001_0010, LEVEL_PRESSED, lanes(0), '0);
      offer_scan(32'h0001_0020, LEVEL_RELEASED, lanes(0), '0);
      // Click limit edges: one under the limit clicks, the limit itself does not.
      offer_scan(32'h0002_0000, LEVEL_PRESSED, lanes(512), '0);
      offer_scan(32'h0002_0000 + 32'd999, LEVEL_RELEASED, lanes(512), '0);
      offer_scan(32'h0003_0000, LEVEL_PRESSED, lanes(512), '0);
      offer_scan(32'h0003_0000 + 32'd1000, LEVEL_RELEASED, lanes(512), '0);
      // Long-press limit edges, then a re-arm and a turn while still held.
      offer_scan(32'h0004_0000, LEVEL_PRESSED, lanes(512), '0);
      offer_scan(32'h0004_0000 + 32'd2000, LEVEL_PRESSED, lanes(512), '0);
      offer_scan(32'h0004_0000 + 32'd2001, LEVEL_PRESSED, lanes(512), 4'hF);
      offer_scan(32'h0004_0000 + 32'd2100, LEVEL_PRESSED, lanes(700), '0);
      offer_scan(32'hFFFF_FFFF, LEVEL_RELEASED, lanes(1023), 4'hA);

      sim_now   = 32'hFFFF_FFFF;
      sim_level = LEVEL_RELEASED;
      for (int k = 0; k < KNOB_MAX; k++) begin
         knob_base[k] = 512;
      end

      // Each phase gets its own register setting and idling pattern, cycling
      // through no idling, a mostly idle sender, a mostly stalling receiver and
      // light idling on both sides.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: retune(0, 16, 1000, 2000);
            1: retune(1, 0, 0, 0);
            2: retune(0, 255, 65535, 65535);
            default: retune($urandom_range(0, 1), $urandom_range(0, 48),
                            $urandom_range(0, 3000), $urandom_range(0, 6000));
         endcase
         case (p % 4)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct <= 0;
            end
            1: begin
               tx_idle_pct  = 77;
               rx_stall_pct <= 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct <= 77;
            end
            default: begin
               tx_idle_pct  = 15;
               rx_stall_pct <= 15;
            end
         endcase
         if (p == 0) begin
            // The receiver holds off while scans keep coming, so the output
            // buffer fills and the block has to stall its input.
            hold_serial <= hold_serial + 1;
            run_scans(PHASE_ITEMS);
         end else if (p == 4) begin
            // Half-way through, the sender rests until every result is home.
            run_scans(PHASE_ITEMS / 2);
            wait_drained();
            run_scans(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_scans(PHASE_ITEMS);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/kbq_pkg.sv
rtl/core/knob_and_button_qualifier.sv
tb/sv/kbq_checker.sv
tb/sv/tb.sv
